### hdl/cdm_pkg.sv
// Shared types and constants for the cosine distance match unit.
// No dependencies; every other file of the unit imports this package.
package cdm_pkg;

  localparam int unsigned VEC_MAX_DEF = 256;
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned ACC_W       = 40;
  localparam int unsigned HALF_W      = 20;
  localparam int unsigned PRODW_W     = 80;
  localparam int unsigned ROOT_W      = 40;
  localparam int unsigned REM_W       = 42;
  localparam int unsigned NORM_W      = 41;
  localparam int unsigned DIVD_W      = 56;
  localparam int unsigned QUO_W       = 16;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned STEP_W      = 6;
  localparam int unsigned ONE_Q14     = 16384;
  localparam logic [DIST_W-1:0] THR_RESET = 16'd4915;

  localparam int unsigned JOBQ_DEPTH = 2;
  localparam int unsigned JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int unsigned JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  // Accumulator snapshot of one finished vector pair.
  typedef struct packed {
    logic [ACC_W-1:0] dot;
    logic [ACC_W-1:0] qsq;
    logic [ACC_W-1:0] rsq;
  } job_t;

  typedef struct packed {
    logic full;
    logic afull;
  } jobq_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SQRT,
    BK_PREP,
    BK_DIV,
    BK_FIN,
    BK_DONE
  } back_state_e;

endpackage

### hdl/cdm_front.sv
// Front end: accepts element pairs, multiplies and accumulates with saturation.
// Depends on cdm_pkg; hands finished accumulator snapshots to cdm_jobq.
module cdm_front #(
  parameter int unsigned VecMax = cdm_pkg::VEC_MAX_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic signed [cdm_pkg::ELEM_W-1:0]      query_elem_i,
  input  logic signed [cdm_pkg::ELEM_W-1:0]      ref_elem_i,
  input  logic                                   last_i,
  input  cdm_pkg::jobq_status_t                  qstat_i,
  output logic                                   job_valid_o,
  output cdm_pkg::job_t                          job_o
);
  import cdm_pkg::*;

  localparam int unsigned CntW = $clog2(VecMax + 1);

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     s1_valid_q, s1_last_q;
  logic signed [PROD_W-1:0] s1_dot_q, s1_dot_d;
  logic [PROD_W-1:0]        s1_qsq_q, s1_qsq_d, s1_rsq_q, s1_rsq_d;
  logic [ACC_W-1:0]         dot_q, qsq_q, rsq_q;
  logic [ACC_W-1:0]         dot_sat, qsq_sat, rsq_sat;
  logic [ACC_W:0]           dot_sum, qsq_sum, rsq_sum;
  logic                     accept, use_elem;
  logic signed [PROD_W-1:0] pq, pr, pqr;

  // A last element in flight takes the last free queue slot in this cycle.
  assign full_o   = qstat_i.full | (qstat_i.afull & s1_valid_q & s1_last_q);
  assign accept   = push_i & ~full_o;
  assign use_elem = (cnt_q < CntW'(VecMax));

  assign pqr = query_elem_i * ref_elem_i;
  assign pq  = query_elem_i * query_elem_i;
  assign pr  = ref_elem_i * ref_elem_i;

  always_comb begin
    s1_dot_d = use_elem ? pqr : '0;
    s1_qsq_d = use_elem ? PROD_W'(pq) : '0;
    s1_rsq_d = use_elem ? PROD_W'(pr) : '0;
    cnt_d    = cnt_q;
    if (accept) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (use_elem) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  assign dot_sum = {dot_q[ACC_W-1], dot_q} + {{(ACC_W+1-PROD_W){s1_dot_q[PROD_W-1]}}, s1_dot_q};
  assign qsq_sum = {1'b0, qsq_q} + {{(ACC_W+1-PROD_W){1'b0}}, s1_qsq_q};
  assign rsq_sum = {1'b0, rsq_q} + {{(ACC_W+1-PROD_W){1'b0}}, s1_rsq_q};

  always_comb begin
    dot_sat = dot_sum[ACC_W-1:0];
    if (dot_sum[ACC_W] != dot_sum[ACC_W-1]) begin
      dot_sat = dot_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    qsq_sat = qsq_sum[ACC_W] ? '1 : qsq_sum[ACC_W-1:0];
    rsq_sat = rsq_sum[ACC_W] ? '1 : rsq_sum[ACC_W-1:0];
  end

  assign job_valid_o = s1_valid_q & s1_last_q;
  assign job_o       = '{dot: dot_sat, qsq: qsq_sat, rsq: rsq_sat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      dot_q      <= '0;
      qsq_q      <= '0;
      rsq_q      <= '0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= accept;
      s1_last_q  <= accept & last_i;
      if (s1_valid_q) begin
        dot_q <= s1_last_q ? '0 : dot_sat;
        qsq_q <= s1_last_q ? '0 : qsq_sat;
        rsq_q <= s1_last_q ? '0 : rsq_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_dot_q <= s1_dot_d;
      s1_qsq_q <= s1_qsq_d;
      s1_rsq_q <= s1_rsq_d;
    end
  end

endmodule

### hdl/cdm_jobq.sv
// Short queue of accumulator snapshots between the front and back ends.
// Depends on cdm_pkg for the job type and the depth.
module cdm_jobq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  cdm_pkg::job_t         push_job_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output cdm_pkg::job_t         job_o,
  output cdm_pkg::jobq_status_t status_o
);
  import cdm_pkg::*;

  job_t                  mem_q [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOBQ_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign valid_o        = (cnt_q != '0);
  assign job_o          = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == JOBQ_CNT_W'(JOBQ_DEPTH));
  assign status_o.afull = (cnt_q == JOBQ_CNT_W'(JOBQ_DEPTH - 1));
  assign do_push        = push_valid_i & ~status_o.full;
  assign do_pop         = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_q + JOBQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_q + JOBQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + JOBQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - JOBQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### hdl/cdm_back.sv
// Back end: norm product, square root, division and threshold compare.
// Depends on cdm_pkg; takes jobs from cdm_jobq and holds one result.
module cdm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  cdm_pkg::job_t                job_i,
  output logic                         job_pop_o,
  input  logic [cdm_pkg::DIST_W-1:0]   thr_i,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [cdm_pkg::DIST_W-1:0]   distance_o,
  output logic                         is_match_o
);
  import cdm_pkg::*;

  back_state_e         state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [ACC_W-1:0]    a_q, a_d, b_q, b_d, dot_q, dot_d;
  logic [PRODW_W-1:0]  prod_q, prod_d, rad_q, rad_d, pp_sh;
  logic [REM_W-1:0]    rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [DIVD_W-1:0]   divr_q, divr_d, dvs_q, dvs_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic [DIST_W-1:0]   dist_q, dist_d, dist_c;
  logic                match_q, match_d;
  logic [HALF_W-1:0]   ah, bh;
  logic [2*HALF_W-1:0] pp;
  logic [ACC_W-1:0]    mag;
  logic [NORM_W-1:0]   norm;
  logic [QUO_W-2:0]    sim_mag;

  assign ah = step_q[1] ? a_q[ACC_W-1:HALF_W] : a_q[HALF_W-1:0];
  assign bh = step_q[0] ? b_q[ACC_W-1:HALF_W] : b_q[HALF_W-1:0];
  assign pp = (2*HALF_W)'(ah) * (2*HALF_W)'(bh);

  always_comb begin
    case (step_q[1:0])
      2'd0:    pp_sh = {{(2*HALF_W){1'b0}}, pp};
      2'd3:    pp_sh = {pp, {(2*HALF_W){1'b0}}};
      default: pp_sh = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
    endcase
  end

  assign rem_sh  = {rem_q[REM_W-3:0], rad_q[PRODW_W-1 -: 2]};
  assign trial   = {root_q, 2'b01};
  assign mag     = dot_q[ACC_W-1] ? (~dot_q + ACC_W'(1)) : dot_q;
  assign norm    = NORM_W'(root_q) + NORM_W'(1);
  assign sim_mag = (quo_q > QUO_W'(ONE_Q14)) ? (QUO_W-1)'(ONE_Q14) : quo_q[QUO_W-2:0];
  assign dist_c  = dot_q[ACC_W-1] ? (DIST_W'(ONE_Q14) + DIST_W'(sim_mag))
                                  : (DIST_W'(ONE_Q14) - DIST_W'(sim_mag));

  assign empty_o    = (state_q != BK_DONE);
  assign distance_o = dist_q;
  assign is_match_o = match_q;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    a_d       = a_q;
    b_d       = b_q;
    dot_d     = dot_q;
    prod_d    = prod_q;
    rad_d     = rad_q;
    rem_d     = rem_q;
    root_d    = root_q;
    divr_d    = divr_q;
    dvs_d     = dvs_q;
    quo_d     = quo_q;
    dist_d    = dist_q;
    match_d   = match_q;
    job_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          a_d       = job_i.qsq;
          b_d       = job_i.rsq;
          dot_d     = job_i.dot;
          prod_d    = '0;
          step_d    = '0;
          state_d   = BK_MUL;
        end
      end
      BK_MUL: begin
        // Four 20x20 partial products make the 80-bit norm product.
        prod_d = prod_q + pp_sh;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(3)) begin
          rad_d   = prod_d;
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = BK_SQRT;
        end
      end
      BK_SQRT: begin
        // One root bit per cycle, two radicand bits consumed.
        rad_d  = {rad_q[PRODW_W-3:0], 2'b00};
        step_d = step_q + STEP_W'(1);
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (step_q == STEP_W'(ROOT_W - 1)) begin
          state_d = BK_PREP;
        end
      end
      BK_PREP: begin
        divr_d  = {{(DIVD_W-ACC_W-14){1'b0}}, mag, 14'd0};
        dvs_d   = {norm, {(DIVD_W-NORM_W){1'b0}}};
        quo_d   = '0;
        step_d  = '0;
        state_d = BK_DIV;
      end
      BK_DIV: begin
        // Restoring division; a set top quotient bit means the result clamps.
        dvs_d  = {1'b0, dvs_q[DIVD_W-1:1]};
        step_d = step_q + STEP_W'(1);
        if (divr_q >= dvs_q) begin
          divr_d = divr_q - dvs_q;
          quo_d  = {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          quo_d  = {quo_q[QUO_W-2:0], 1'b0};
        end
        if (step_q == STEP_W'(QUO_W - 1)) begin
          state_d = BK_FIN;
        end
      end
      BK_FIN: begin
        dist_d  = dist_c;
        match_d = (dist_c < thr_i);
        state_d = BK_DONE;
      end
      BK_DONE: begin
        if (pop_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    dot_q   <= dot_d;
    prod_q  <= prod_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    divr_q  <= divr_d;
    dvs_q   <= dvs_d;
    quo_q   <= quo_d;
    dist_q  <= dist_d;
    match_q <= match_d;
  end

endmodule

### hdl/cosine_distance_match_unit.sv
// Top level of the cosine distance match unit.
// Depends on cdm_pkg, cdm_front, cdm_jobq and cdm_back.
//
// The unit streams two feature vectors as element pairs (signed Q3.12) and,
// on the element marked last, reports the cosine distance 1 - x.y/(|x||y|)
// in unsigned Q2.14 together with a match flag that is set when the distance
// is strictly below the match_threshold register (reset value 0.3). Both
// sides look like a queue: push an element while full is low, pop a result
// while empty is low. The front end takes one element per cycle and keeps
// three saturating 40-bit accumulators; elements beyond VecMax in one vector
// are dropped, but a last flag on them still closes the vector. Each closed
// vector leaves a snapshot in a two-entry queue, and the back end works on
// one snapshot at a time: the 80-bit norm product as four partial products
// on a 20x20 multiplier, the bit-serial square root and the restoring
// division, plus setup and the final compare. That back-end sequencer sets
// the rate per vector; streaming elements stalls only when two closed
// vectors are already waiting. Write the threshold only while no
// transaction is in progress.
module cosine_distance_match_unit #(
  parameter int unsigned VecMax = cdm_pkg::VEC_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cdm_pkg::DIST_W-1:0]          cfg_wdata_i,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic signed [cdm_pkg::ELEM_W-1:0]   query_elem_i,
  input  logic signed [cdm_pkg::ELEM_W-1:0]   ref_elem_i,
  input  logic                                last_i,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic [cdm_pkg::DIST_W-1:0]          distance_o,
  output logic                                is_match_o
);
  import cdm_pkg::*;

  logic [DIST_W-1:0] thr_q;
  logic              fe_job_valid, q_valid, q_pop;
  job_t              fe_job, q_job;
  jobq_status_t      q_status;

  // The threshold register; it is sampled when a result is formed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  cdm_front #(
    .VecMax(VecMax)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .query_elem_i(query_elem_i),
    .ref_elem_i  (ref_elem_i),
    .last_i      (last_i),
    .qstat_i     (q_status),
    .job_valid_o (fe_job_valid),
    .job_o       (fe_job)
  );

  cdm_jobq u_jobq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fe_job_valid),
    .push_job_i  (fe_job),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .job_o       (q_job),
    .status_o    (q_status)
  );

  cdm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (q_job),
    .job_pop_o  (q_pop),
    .thr_i      (thr_q),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .distance_o (distance_o),
    .is_match_o (is_match_o)
  );

endmodule

### hdl/cdm_checker.sv
// Port-level checks for the cosine distance match unit.
// Depends on cdm_pkg; bound to cosine_distance_match_unit at the end of this file.
module cdm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [cdm_pkg::DIST_W-1:0]          cfg_wdata_i,
  input logic                                empty_o,
  input logic                                pop_i,
  input logic [cdm_pkg::DIST_W-1:0]          distance_o,
  input logic                                is_match_o
);
  import cdm_pkg::*;

  logic [DIST_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // A distance never exceeds 2.0 in Q2.14.
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (distance_o <= DIST_W'(2 * ONE_Q14)))
    else $error("distance above 2.0");

  // The match flag agrees with the programmed threshold.
  a_match_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (is_match_o == (distance_o < thr_q)))
    else $error("match flag disagrees with threshold");

  // A waiting result stays put until it is popped.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(distance_o) && $stable(is_match_o)))
    else $error("waiting result changed");

endmodule

bind cosine_distance_match_unit cdm_checker u_cdm_checker (.*);
